FILE: rtl/pfa_pkg.sv
// Package with the shared types and constants of the page frame allocator.
package pfa_pkg;

  localparam int PID_IN_W = 8;
  localparam int VPAGE_W  = 20;
  localparam int FRAME_W  = 9;
  localparam int COUNT_W  = 10;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_ASSIGN = 2'd1,
    CMD_FREE   = 2'd2,
    CMD_MARK   = 2'd3
  } pfa_cmd_e;

  // One frame table entry, without the owner whose width is a parameter.
  typedef struct packed {
    logic               used;
    logic               is_table;
    logic [VPAGE_W-1:0] vpage;
  } pfa_entry_t;

  // Result handed from the scan unit to the top level ports.
  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] alloc_frame;
    logic               status;
    logic [COUNT_W-1:0] released;
    logic [COUNT_W-1:0] tables;
  } pfa_result_t;

endpackage

FILE: rtl/page_frame_allocator_top.sv
// Top level of the page frame allocator: a rotating ring of frame cells and a scan unit.
// A result is strobed once every table entry has passed the scan unit and the result has
// been registered. The block takes no new transaction while one is running: the ring rotates
// one entry per cycle past the single scan unit, and only while a transaction runs. Reset
// clears the whole table at once, with no clearing pass; the receiver cannot stall, so each
// result is valid for exactly one cycle.
module page_frame_allocator_top #(
  parameter int FRAME_COUNT = 512,
  parameter int PID_WIDTH   = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         cmd_i,
  input  logic [pfa_pkg::PID_IN_W-1:0]       owner_pid_i,
  input  logic [pfa_pkg::VPAGE_W-1:0]        virtual_page_i,
  input  logic [pfa_pkg::FRAME_W-1:0]        frame_index_i,
  output logic                               result_valid_o,
  output logic [pfa_pkg::FRAME_W-1:0]        alloc_frame_o,
  output logic                               status_o,
  output logic [pfa_pkg::COUNT_W-1:0]        released_count_o,
  output logic [pfa_pkg::COUNT_W-1:0]        table_count_o
);

  // The frame table lives in a ring of cells. Cell k starts out holding frame k. While a
  // transaction is running the ring shifts by one cell each cycle toward cell 0; the entry
  // leaving cell 0 goes through the scan unit, which applies the command to it, and
  // re-enters at the last cell. After FRAME_COUNT shifts every entry is back in its home
  // cell, and the scan unit has seen the frames in ascending order, so the step counter
  // in the scan unit is the frame number of the entry it is looking at.
  pfa_pkg::pfa_entry_t  entry_w [FRAME_COUNT];
  logic [PID_WIDTH-1:0] owner_w [FRAME_COUNT];
  pfa_pkg::pfa_entry_t  tail_entry;
  logic [PID_WIDTH-1:0] tail_owner;
  logic                 shift;
  pfa_pkg::pfa_result_t result;

  for (genvar k = 0; k < FRAME_COUNT; k++) begin : g_ring
    if (k == FRAME_COUNT - 1) begin : g_last
      pfa_cell #(
        .PID_WIDTH (PID_WIDTH)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .entry_i (tail_entry),
        .owner_i (tail_owner),
        .entry_o (entry_w[k]),
        .owner_o (owner_w[k])
      );
    end else begin : g_mid
      pfa_cell #(
        .PID_WIDTH (PID_WIDTH)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .entry_i (entry_w[k+1]),
        .owner_i (owner_w[k+1]),
        .entry_o (entry_w[k]),
        .owner_o (owner_w[k])
      );
    end
  end

  // The scan unit holds the command, the step counter and the running search and release
  // counts; it registers the result when the last entry has gone by.
  pfa_scan #(
    .FRAME_COUNT (FRAME_COUNT),
    .PID_WIDTH   (PID_WIDTH)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .cmd_i          (pfa_pkg::pfa_cmd_e'(cmd_i)),
    .owner_pid_i    (owner_pid_i),
    .virtual_page_i (virtual_page_i),
    .frame_index_i  (frame_index_i),
    .head_entry_i   (entry_w[0]),
    .head_owner_i   (owner_w[0]),
    .tail_entry_o   (tail_entry),
    .tail_owner_o   (tail_owner),
    .shift_o        (shift),
    .busy_o         (busy),
    .result_o       (result)
  );

  assign result_valid_o   = result.valid;
  assign alloc_frame_o    = result.alloc_frame;
  assign status_o         = result.status;
  assign released_count_o = result.released;
  assign table_count_o    = result.tables;

endmodule

FILE: rtl/pfa_cell.sv
// One cell of the rotating frame table: holds one entry and passes it on.
module pfa_cell #(
  parameter int PID_WIDTH = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 shift_i,
  input  pfa_pkg::pfa_entry_t  entry_i,
  input  logic [PID_WIDTH-1:0] owner_i,
  output pfa_pkg::pfa_entry_t  entry_o,
  output logic [PID_WIDTH-1:0] owner_o
);

  pfa_pkg::pfa_entry_t  entry_d, entry_q;
  logic [PID_WIDTH-1:0] owner_d, owner_q;

  assign entry_d = entry_i;
  assign owner_d = owner_i;

  // The table is defined as all zero after reset, so every cell clears.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      owner_q <= '0;
    end else if (shift_i) begin
      entry_q <= entry_d;
      owner_q <= owner_d;
    end
  end

  assign entry_o = entry_q;
  assign owner_o = owner_q;

endmodule

FILE: rtl/pfa_scan.sv
// Scan unit: applies the current command to the entry leaving the head cell.
module pfa_scan #(
  parameter int FRAME_COUNT = 512,
  parameter int PID_WIDTH   = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  pfa_pkg::pfa_cmd_e                 cmd_i,
  input  logic [pfa_pkg::PID_IN_W-1:0]      owner_pid_i,
  input  logic [pfa_pkg::VPAGE_W-1:0]       virtual_page_i,
  input  logic [pfa_pkg::FRAME_W-1:0]       frame_index_i,
  input  pfa_pkg::pfa_entry_t               head_entry_i,
  input  logic [PID_WIDTH-1:0]              head_owner_i,
  output pfa_pkg::pfa_entry_t               tail_entry_o,
  output logic [PID_WIDTH-1:0]              tail_owner_o,
  output logic                              shift_o,
  output logic                              busy_o,
  output pfa_pkg::pfa_result_t              result_o
);

  localparam int IdxW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int CmpW = (IdxW > pfa_pkg::FRAME_W) ? IdxW : pfa_pkg::FRAME_W;
  localparam logic [IdxW-1:0] LastStep = IdxW'(FRAME_COUNT - 1);

  logic                          busy_q;
  logic [IdxW-1:0]               step_q;
  logic                          res_valid_q;
  pfa_pkg::pfa_cmd_e             cmd_q;
  logic [PID_WIDTH-1:0]          pid_q;
  logic [pfa_pkg::VPAGE_W-1:0]   vpage_q;
  logic [pfa_pkg::FRAME_W-1:0]   fidx_q;
  logic                          found_d, found_q;
  logic [pfa_pkg::FRAME_W-1:0]   grant_d, grant_q;
  logic [pfa_pkg::COUNT_W-1:0]   rel_d, rel_q;
  logic [pfa_pkg::COUNT_W-1:0]   tab_d, tab_q;
  logic [pfa_pkg::FRAME_W-1:0]   res_frame_q;
  logic                          res_status_q;
  logic [pfa_pkg::COUNT_W-1:0]   res_rel_q;
  logic [pfa_pkg::COUNT_W-1:0]   res_tab_q;
  logic                          accept;
  logic                          last_step;
  logic                          index_hit;
  logic                          owner_hit;

  assign accept    = start_i && !busy_q;
  assign last_step = busy_q && (step_q == LastStep);
  assign index_hit = (CmpW'(fidx_q) == CmpW'(step_q));
  assign owner_hit = head_entry_i.used && (head_owner_i == pid_q);

  always_comb begin
    tail_entry_o = head_entry_i;
    tail_owner_o = head_owner_i;
    found_d      = found_q;
    grant_d      = grant_q;
    rel_d        = rel_q;
    tab_d        = tab_q;
    case (cmd_q)
      pfa_pkg::CMD_ALLOC: begin
        if (!found_q && !head_entry_i.used) begin
          tail_entry_o.used = 1'b1;
          found_d           = 1'b1;
          grant_d           = pfa_pkg::FRAME_W'(step_q);
        end
      end
      pfa_pkg::CMD_ASSIGN: begin
        if (index_hit) begin
          tail_owner_o       = pid_q;
          tail_entry_o.vpage = vpage_q;
        end
      end
      pfa_pkg::CMD_FREE: begin
        if (owner_hit) begin
          if (rel_q != pfa_pkg::COUNT_MAX) begin
            rel_d = rel_q + 1'b1;
          end
          if (head_entry_i.is_table && (tab_q != pfa_pkg::COUNT_MAX)) begin
            tab_d = tab_q + 1'b1;
          end
          tail_entry_o = '0;
          tail_owner_o = '0;
        end
      end
      pfa_pkg::CMD_MARK: begin
        if (index_hit) begin
          tail_owner_o          = pid_q;
          tail_entry_o.is_table = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= last_step;
      if (accept) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      pid_q   <= PID_WIDTH'(owner_pid_i);
      vpage_q <= virtual_page_i;
      fidx_q  <= frame_index_i;
      found_q <= 1'b0;
      grant_q <= '0;
      rel_q   <= '0;
      tab_q   <= '0;
    end else if (busy_q) begin
      found_q <= found_d;
      grant_q <= grant_d;
      rel_q   <= rel_d;
      tab_q   <= tab_d;
    end
    if (last_step) begin
      res_frame_q  <= (cmd_q == pfa_pkg::CMD_ALLOC) ? grant_d : '0;
      res_status_q <= (cmd_q == pfa_pkg::CMD_ALLOC) && !found_d;
      res_rel_q    <= rel_d;
      res_tab_q    <= tab_d;
    end
  end

  assign shift_o              = busy_q;
  assign busy_o               = busy_q;
  assign result_o.valid       = res_valid_q;
  assign result_o.alloc_frame = res_frame_q;
  assign result_o.status      = res_status_q;
  assign result_o.released    = res_rel_q;
  assign result_o.tables      = res_tab_q;

  a_result_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> res_valid_q)
    else $error("scan ended without a result strobe");

  a_result_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> !busy_q)
    else $error("result strobe while a scan is running");

  a_scan_starts_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (step_q == '0)) |-> $past(start_i && !busy_q))
    else $error("scan at first entry without an accepted transaction");

  a_oom_no_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_status_q) |-> ((res_rel_q == '0) && (res_tab_q == '0)))
    else $error("out-of-memory result carries release counts");

  a_tables_within_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_tab_q <= res_rel_q))
    else $error("more page tables released than frames");

endmodule
